[hw/rtl/combined_lcg_shuffle_rng_defines.svh]
// Assertion macros shared by the combined LCG shuffle generator RTL
`ifndef COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define CLSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition that must never hold
`define CLSR_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

[hw/rtl/clsr_pkg.sv]
// Package: constants shared by the combined LCG shuffle generator
`timescale 1ns / 1ps

package clsr_pkg;

    localparam int TABLE_SIZE = 32;

    localparam int WORD_W = 31;
    localparam int MUL_W  = 16;
    localparam int FOLD_W = 8;

    // item kinds
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    // multipliers and fold constants (modulus = 2^31 - fold)
    localparam logic [MUL_W-1:0]  MUL_ONE  = 16'd40014;
    localparam logic [MUL_W-1:0]  MUL_TWO  = 16'd40692;
    localparam logic [FOLD_W-1:0] FOLD_ONE = 8'd85;
    localparam logic [FOLD_W-1:0] FOLD_TWO = 8'd249;

    localparam logic [WORD_W-1:0] SPAN      = 31'd2147483562;
    localparam logic [WORD_W-1:0] GEN_ONE_INIT = 31'd1;
    localparam logic [WORD_W-1:0] GEN_TWO_INIT = 31'd123456789;

    // slot index by reciprocal multiply
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = 18;
    localparam int EST_W       = 9;

endpackage

[hw/rtl/clsr_lcg_step.sv]
// Three-stage modular multiply: x * MUL mod (2^31 - FOLD)
`timescale 1ns / 1ps

module clsr_lcg_step #(
    parameter logic [clsr_pkg::MUL_W-1:0]  MUL  = clsr_pkg::MUL_ONE,
    parameter logic [clsr_pkg::FOLD_W-1:0] FOLD = clsr_pkg::FOLD_ONE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [clsr_pkg::WORD_W-1:0] i_x,
    output logic                        o_valid,
    output logic [clsr_pkg::WORD_W-1:0] o_res
);

    localparam int WORD_W = clsr_pkg::WORD_W;
    localparam int PROD_W = WORD_W + clsr_pkg::MUL_W;
    localparam int HC_W   = clsr_pkg::MUL_W + clsr_pkg::FOLD_W;
    localparam logic [WORD_W:0] MOD = ((WORD_W+1)'(1) << WORD_W) - (WORD_W+1)'(FOLD);

    logic [2:0]              r_vld;
    logic [PROD_W-1:0]       r_prod;
    logic [WORD_W:0]         r_fold;
    logic [WORD_W-1:0]       r_res;
    logic [HC_W-1:0]         hc;

    // 2^31 == FOLD (mod m): fold the high part back in
    assign hc = r_prod[PROD_W-1:WORD_W] * FOLD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 3'b000;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_x * MUL;
        r_fold <= {1'b0, r_prod[WORD_W-1:0]} + (WORD_W+1)'(hc);
        if (r_fold >= MOD) begin
            r_res <= WORD_W'(r_fold - MOD);
        end else begin
            r_res <= r_fold[WORD_W-1:0];
        end
    end

    assign o_valid = r_vld[2];
    assign o_res   = r_res;

endmodule

[hw/rtl/clsr_slot_div.sv]
// Three-stage slot index: last deviate divided by the slot width
`timescale 1ns / 1ps

module clsr_slot_div #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [clsr_pkg::WORD_W-1:0]  i_x,
    output logic                         o_valid,
    output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] o_slot
);

    localparam int IDX_W   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int WORD_W  = clsr_pkg::WORD_W;
    localparam int RECIP_W = clsr_pkg::RECIP_W;
    localparam int EST_W   = clsr_pkg::EST_W;
    localparam int THR_W   = WORD_W + EST_W;
    localparam logic [63:0] DIV64   = 64'd1 + 64'(clsr_pkg::SPAN) / 64'(TABLE_SIZE);
    localparam logic [63:0] RECIP64 = (64'd1 << clsr_pkg::RECIP_SHIFT) / DIV64;
    localparam logic [WORD_W-1:0]  SLOT_DIV = DIV64[WORD_W-1:0];
    localparam logic [RECIP_W-1:0] RECIP    = RECIP64[RECIP_W-1:0];
    localparam logic [EST_W-1:0]   LAST     = EST_W'(TABLE_SIZE - 1);

    logic [2:0]                 r_vld;
    logic [EST_W-1:0]           r_est;
    logic [EST_W-1:0]           r_est2;
    logic [WORD_W-1:0]          r_x1;
    logic [WORD_W-1:0]          r_x2;
    logic [THR_W-1:0]           r_thr;
    logic [IDX_W-1:0]           r_slot;
    logic [WORD_W+RECIP_W-1:0]  prod;
    logic [EST_W-1:0]           est_p1;
    logic [EST_W-1:0]           quo;
    logic [EST_W-1:0]           quo_sat;

    // estimate is exact or one low
    assign prod    = i_x * RECIP;
    assign est_p1  = r_est + 1'b1;
    assign quo     = ({{EST_W{1'b0}}, r_x2} >= r_thr) ? r_est2 + 1'b1 : r_est2;
    assign quo_sat = (quo > LAST) ? LAST : quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 3'b000;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_est  <= prod[clsr_pkg::RECIP_SHIFT +: EST_W];
        r_x1   <= i_x;
        r_thr  <= est_p1 * SLOT_DIV;
        r_est2 <= r_est;
        r_x2   <= r_x1;
        r_slot <= quo_sat[IDX_W-1:0];
    end

    assign o_valid = r_vld[2];
    assign o_slot  = r_slot;

endmodule

[hw/rtl/clsr_shuffle_ram.sv]
// Shuffle table RAM: one write port, one registered read port
`timescale 1ns / 1ps

module clsr_shuffle_ram #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] i_wr_addr,
    input  logic [clsr_pkg::WORD_W-1:0]  i_wr_data,
    input  logic                         i_rd_en,
    input  logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] i_rd_addr,
    output logic [clsr_pkg::WORD_W-1:0]  o_rd_data
);

    logic [clsr_pkg::WORD_W-1:0] r_mem [TABLE_SIZE];
    logic [clsr_pkg::WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/combined_lcg_shuffle_rng.sv]
// Top level: combined two-LCG generator with a RAM-held shuffle table.
// Draw: the request runs through the 3-stage modular multiply / slot pipeline, then the table read
// and write-back, where the result is registered; no new request is taken until that result is loaded.
// Reseed: one multiply pass per step; the last steps fill the table, then a draw follows.
// Reset (synchronous): generators to 1 and 123456789, last deviate to 0; table unset until reseed.
`timescale 1ns / 1ps
`include "combined_lcg_shuffle_rng_defines.svh"

module combined_lcg_shuffle_rng #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_kind,
    input  logic [clsr_pkg::WORD_W-1:0] i_seed_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [clsr_pkg::WORD_W-1:0] o_deviate
);

    localparam int WORD_W = clsr_pkg::WORD_W;
    localparam int IDX_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W  = $clog2(TABLE_SIZE + 9);
    localparam logic [CNT_W-1:0] FILL_STEPS = CNT_W'(TABLE_SIZE + 8);
    localparam logic [CNT_W-1:0] FILL_FIRST = CNT_W'(TABLE_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(1);

    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_SEED_WAIT = 2'd1;
    localparam logic [1:0] ST_DRAW_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE      = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [WORD_W-1:0] r_gen_one;
    logic [WORD_W-1:0] r_gen_two;
    logic [WORD_W-1:0] r_shuffle_out;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_deviate;
    logic [IDX_W-1:0]  r_slot;

    logic              accept;
    logic [WORD_W-1:0] seed_fix;
    logic [WORD_W-1:0] one_x;
    logic              one_start;
    logic              one_valid;
    logic [WORD_W-1:0] one_res;
    logic              draw_start;
    logic              two_valid;
    logic [WORD_W-1:0] two_res;
    logic [WORD_W-1:0] slot_x;
    logic              slot_valid;
    logic [IDX_W-1:0]  slot_idx;
    logic [CNT_W-1:0]  cnt_m1;
    logic              last_step;
    logic              seed_step;
    logic              out_free;
    logic              fill_wr;
    logic              done_wr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W:0]   diff;
    logic [WORD_W:0]   diff_wrap;
    logic [WORD_W-1:0] n_deviate;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign seed_fix   = (i_seed_value == '0) ? WORD_W'(1) : i_seed_value;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign seed_step  = (r_state == ST_SEED_WAIT) && one_valid;
    assign cnt_m1     = r_cnt - 1'b1;
    assign last_step  = (r_cnt == CNT_LAST);

    assign one_x      = (r_state == ST_SEED_WAIT) ? one_res :
                        ((i_kind == clsr_pkg::KIND_RESEED) ? seed_fix : r_gen_one);
    assign one_start  = accept || seed_step;
    assign draw_start = (accept && (i_kind == clsr_pkg::KIND_DRAW)) ||
                        (seed_step && last_step);
    // after the fill the last step value is slot 0, the selector for the draw
    assign slot_x     = (r_state == ST_SEED_WAIT) ? one_res : r_shuffle_out;

    clsr_lcg_step #(
        .MUL  (clsr_pkg::MUL_ONE),
        .FOLD (clsr_pkg::FOLD_ONE)
    ) u_step_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (one_start),
        .i_x     (one_x),
        .o_valid (one_valid),
        .o_res   (one_res)
    );

    clsr_lcg_step #(
        .MUL  (clsr_pkg::MUL_TWO),
        .FOLD (clsr_pkg::FOLD_TWO)
    ) u_step_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (draw_start),
        .i_x     (r_gen_two),
        .o_valid (two_valid),
        .o_res   (two_res)
    );

    clsr_slot_div #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_slot_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (draw_start),
        .i_x     (slot_x),
        .o_valid (slot_valid),
        .o_slot  (slot_idx)
    );

    // table fill runs from the top slot down to slot 0
    assign fill_wr = seed_step && (r_cnt <= FILL_FIRST);
    assign done_wr = (r_state == ST_DONE) && out_free;
    assign wr_en   = fill_wr || done_wr;
    assign wr_addr = fill_wr ? cnt_m1[IDX_W-1:0] : r_slot;
    assign wr_data = fill_wr ? one_res : r_gen_one;
    assign rd_en   = (r_state == ST_DRAW_WAIT) && one_valid;

    clsr_shuffle_ram #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_shuffle_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (slot_idx),
        .o_rd_data (rd_data)
    );

    assign diff      = {1'b0, rd_data} - {1'b0, r_gen_two};
    assign diff_wrap = diff + {1'b0, clsr_pkg::SPAN};
    assign n_deviate = (diff[WORD_W] || (diff == '0)) ? diff_wrap[WORD_W-1:0]
                                                     : diff[WORD_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_kind == clsr_pkg::KIND_RESEED) ? ST_SEED_WAIT : ST_DRAW_WAIT;
                end
            end
            ST_SEED_WAIT: begin
                if (seed_step && last_step) begin
                    n_state = ST_DRAW_WAIT;
                end
            end
            ST_DRAW_WAIT: begin
                if (one_valid) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_gen_one     <= clsr_pkg::GEN_ONE_INIT;
            r_gen_two     <= clsr_pkg::GEN_TWO_INIT;
            r_shuffle_out <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && (i_kind == clsr_pkg::KIND_RESEED)) begin
                r_gen_two <= seed_fix;
                r_cnt     <= FILL_STEPS;
            end
            if (seed_step) begin
                r_gen_one <= one_res;
                r_cnt     <= cnt_m1;
            end
            if (rd_en) begin
                r_gen_one <= one_res;
                r_gen_two <= two_res;
            end
            if (done_wr) begin
                r_shuffle_out <= n_deviate;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_slot <= slot_idx;
        end
        if (done_wr) begin
            r_deviate <= n_deviate;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_deviate   = r_deviate;

    `CLSR_ASSERT_NOW(a_draw_units_aligned, rd_en, two_valid && slot_valid, "draw units out of step")
    `CLSR_ASSERT_NEXT(a_read_then_done, rd_en, r_state == ST_DONE, "table read not followed by done")
    `CLSR_ASSERT_NEVER(a_no_rw_overlap, wr_en && rd_en, "table read and write in one cycle")
    `CLSR_ASSERT_NEXT(a_done_delivers, done_wr, o_out_valid && (r_state == ST_IDLE), "result not loaded")

endmodule
